/* rtl/core/matrix3_inverse_adjugate_core_macros.svh */
// Assertion macros shared by the matrix inverse core.
`ifndef MATRIX3_INVERSE_ADJUGATE_CORE_MACROS_SVH
`define MATRIX3_INVERSE_ADJUGATE_CORE_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define M3INV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define M3INV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/m3inv_pkg.sv */
// Types and constants for the 3x3 adjugate matrix inverse core.
package m3inv_pkg;

	localparam int DATA_W     = 32;
	localparam int PROD_W     = 2 * DATA_W;
	localparam int MAG_W      = PROD_W - 1;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = DATA_W / DIV_STEPS;
	localparam int LANE_LAT   = DIV_STAGES + 3;
	localparam int CORE_LAT   = LANE_LAT + 2;
	localparam int N_ELEM     = 9;

	localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] q;
	} div_st_t;

	typedef struct packed {
		logic zero;
		logic ovf;
	} lane_flags_t;

endpackage

/* rtl/core/matrix3_inverse_adjugate_core.sv */
// Pipeline from input transfer to result valid: 2 cofactor stages, then per
// lane: magnitude, range check, 16 two-bit divide stages, saturate.
// One matrix per cycle unless stalled; nine divide lanes run side by side.
// A stall with out_valid high freezes the whole pipeline and sets in_stall.
// Reset clears only the valid bits; data registers are not reset.
module matrix3_inverse_adjugate_core import m3inv_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] m00,
	input  logic signed [DATA_W-1:0] m01,
	input  logic signed [DATA_W-1:0] m02,
	input  logic signed [DATA_W-1:0] m10,
	input  logic signed [DATA_W-1:0] m11,
	input  logic signed [DATA_W-1:0] m12,
	input  logic signed [DATA_W-1:0] m20,
	input  logic signed [DATA_W-1:0] m21,
	input  logic signed [DATA_W-1:0] m22,
	input  logic signed [DATA_W-1:0] det_in,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] r00,
	output logic signed [DATA_W-1:0] r01,
	output logic signed [DATA_W-1:0] r02,
	output logic signed [DATA_W-1:0] r10,
	output logic signed [DATA_W-1:0] r11,
	output logic signed [DATA_W-1:0] r12,
	output logic signed [DATA_W-1:0] r20,
	output logic signed [DATA_W-1:0] r21,
	output logic signed [DATA_W-1:0] r22,
	output logic                     singular,
	output logic                     overflow
);

	`include "matrix3_inverse_adjugate_core_macros.svh"

	logic                     adv;
	logic [CORE_LAT-1:0]      vld_q;

	logic signed [DATA_W-1:0] op_p [N_ELEM];
	logic signed [DATA_W-1:0] op_q [N_ELEM];
	logic signed [DATA_W-1:0] op_r [N_ELEM];
	logic signed [DATA_W-1:0] op_s [N_ELEM];

	logic signed [PROD_W-1:0] mul_a_s1 [N_ELEM];
	logic signed [PROD_W-1:0] mul_b_s1 [N_ELEM];
	logic signed [DATA_W-1:0] det_s1;
	logic signed [PROD_W-1:0] adj_s2 [N_ELEM];
	logic signed [DATA_W-1:0] det_s2;

	logic [DATA_W-1:0]        res    [N_ELEM];
	lane_flags_t              lflags [N_ELEM];
	logic [N_ELEM-1:0]        ovf_vec;
	logic [N_ELEM-1:0]        sat_vec;
	logic [N_ELEM-1:0]        nz_vec;

	assign adv       = !(out_valid && out_stall);
	assign in_stall  = !adv;
	assign out_valid = vld_q[CORE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[CORE_LAT-2:0], in_valid};
		end
	end

	// adjugate element i = p*s - q*r, already transposed
	always_comb begin
		op_p[0] = m11; op_q[0] = m12; op_r[0] = m21; op_s[0] = m22;
		op_p[1] = m02; op_q[1] = m01; op_r[1] = m22; op_s[1] = m21;
		op_p[2] = m01; op_q[2] = m02; op_r[2] = m11; op_s[2] = m12;
		op_p[3] = m12; op_q[3] = m10; op_r[3] = m22; op_s[3] = m20;
		op_p[4] = m00; op_q[4] = m02; op_r[4] = m20; op_s[4] = m22;
		op_p[5] = m02; op_q[5] = m00; op_r[5] = m12; op_s[5] = m10;
		op_p[6] = m10; op_q[6] = m11; op_r[6] = m20; op_s[6] = m21;
		op_p[7] = m01; op_q[7] = m00; op_r[7] = m21; op_s[7] = m20;
		op_p[8] = m00; op_q[8] = m01; op_r[8] = m10; op_s[8] = m11;
	end

	for (genvar i = 0; i < N_ELEM; i++) begin : g_elem
		always_ff @(posedge clk) begin
			if (adv) begin
				mul_a_s1[i] <= PROD_W'(op_p[i]) * PROD_W'(op_s[i]);
				mul_b_s1[i] <= PROD_W'(op_q[i]) * PROD_W'(op_r[i]);
				adj_s2[i]   <= mul_a_s1[i] - mul_b_s1[i];
			end
		end

		m3inv_div_lane u_lane (
			.clk   (clk),
			.adv   (adv),
			.num   (adj_s2[i]),
			.den   (det_s2),
			.res   (res[i]),
			.flags (lflags[i])
		);

		assign ovf_vec[i] = lflags[i].ovf;
		assign sat_vec[i] = (res[i] == MAX_POS) || (res[i] == MIN_NEG);
		assign nz_vec[i]  = |res[i];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s1 <= det_in;
			det_s2 <= det_s1;
		end
	end

	assign r00      = res[0];
	assign r01      = res[1];
	assign r02      = res[2];
	assign r10      = res[3];
	assign r11      = res[4];
	assign r12      = res[5];
	assign r20      = res[6];
	assign r21      = res[7];
	assign r22      = res[8];
	assign singular = lflags[0].zero;
	assign overflow = |ovf_vec;

	`M3INV_ASSERT_IMP(a_singular_zero, clk, arst_n, out_valid && singular, !(|nz_vec) && !overflow, "singular result not zero")
	`M3INV_ASSERT_IMP(a_ovf_saturated, clk, arst_n, out_valid && overflow, |sat_vec, "overflow without a saturated element")
	`M3INV_ASSERT_NXT(a_accept_tracked, clk, arst_n, in_valid && !in_stall, vld_q[0], "accepted transfer lost its valid bit")

endmodule

/* rtl/core/m3inv_div_lane.sv */
// One pipelined divide-and-saturate lane: adjugate element over determinant.
module m3inv_div_lane import m3inv_pkg::*; (
	input  logic                     clk,
	input  logic                     adv,
	input  logic signed [PROD_W-1:0] num,
	input  logic signed [DATA_W-1:0] den,
	output logic        [DATA_W-1:0] res,
	output lane_flags_t              flags
);

	function automatic div_st_t div_iter(input div_st_t st, input logic [DATA_W-1:0] ud);
		div_st_t         nx;
		logic [DATA_W:0] trial;
		logic [DATA_W:0] diff;
		nx = st;
		for (int j = 0; j < DIV_STEPS; j++) begin
			trial = {nx.rem, nx.lo[DATA_W-1]};
			diff  = trial - {1'b0, ud};
			nx.lo = {nx.lo[DATA_W-2:0], 1'b0};
			if (trial >= {1'b0, ud}) begin
				nx.rem = diff[DATA_W-1:0];
				nx.q   = {nx.q[DATA_W-2:0], 1'b1};
			end else begin
				nx.rem = trial[DATA_W-1:0];
				nx.q   = {nx.q[DATA_W-2:0], 1'b0};
			end
		end
		return nx;
	endfunction

	logic [PROD_W-1:0] num_abs;
	logic [DATA_W-1:0] den_abs;

	logic [MAG_W-1:0]  un_s1;
	logic [DATA_W-1:0] ud_s1;
	logic              neg_s1;
	logic              zero_s1;

	div_st_t           div_sd  [DIV_STAGES+1];
	logic [DATA_W-1:0] ud_sd   [DIV_STAGES+1];
	logic              neg_sd  [DIV_STAGES+1];
	logic              zero_sd [DIV_STAGES+1];
	logic              big_sd  [DIV_STAGES+1];

	logic [DATA_W-1:0] res_nx;
	logic              ovf_nx;
	logic [DATA_W-1:0] q_fin;

	assign num_abs = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
	assign den_abs = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);

	always_ff @(posedge clk) begin
		if (adv) begin
			un_s1   <= num_abs[MAG_W-1:0];
			ud_s1   <= den_abs;
			neg_s1  <= num[PROD_W-1] ^ den[DATA_W-1];
			zero_s1 <= (den == '0);
		end
	end

	// high half already >= divisor means the quotient needs more than DATA_W bits
	always_ff @(posedge clk) begin
		if (adv) begin
			div_sd[0].rem <= DATA_W'(un_s1[MAG_W-1:DATA_W]);
			div_sd[0].lo  <= un_s1[DATA_W-1:0];
			div_sd[0].q   <= '0;
			ud_sd[0]      <= ud_s1;
			neg_sd[0]     <= neg_s1;
			zero_sd[0]    <= zero_s1;
			big_sd[0]     <= (DATA_W'(un_s1[MAG_W-1:DATA_W]) >= ud_s1);
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv) begin
				div_sd[k+1]  <= div_iter(div_sd[k], ud_sd[k]);
				ud_sd[k+1]   <= ud_sd[k];
				neg_sd[k+1]  <= neg_sd[k];
				zero_sd[k+1] <= zero_sd[k];
				big_sd[k+1]  <= big_sd[k];
			end
		end
	end

	assign q_fin = div_sd[DIV_STAGES].q;

	always_comb begin
		res_nx = '0;
		ovf_nx = 1'b0;
		if (zero_sd[DIV_STAGES]) begin
			res_nx = '0;
			ovf_nx = 1'b0;
		end else if (!neg_sd[DIV_STAGES]) begin
			if (big_sd[DIV_STAGES] || q_fin[DATA_W-1]) begin
				res_nx = MAX_POS;
				ovf_nx = 1'b1;
			end else begin
				res_nx = q_fin;
			end
		end else begin
			if (big_sd[DIV_STAGES] || (q_fin > MIN_NEG)) begin
				res_nx = MIN_NEG;
				ovf_nx = 1'b1;
			end else begin
				res_nx = ~q_fin + DATA_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res        <= res_nx;
			flags.ovf  <= ovf_nx;
			flags.zero <= zero_sd[DIV_STAGES];
		end
	end

endmodule
